/* rtl/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that cause at one edge implies effect at the next edge.
`define ASSERT_NEXT(label, cause, effect, msg) \
	`ASSERT_CLK(label, (cause) |=> (effect), msg)

`endif

/* rtl/sha1_pkg.sv */
package sha1_pkg;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_w0;
		logic [31:0] digest_w1;
		logic [31:0] digest_w2;
		logic [31:0] digest_w3;
		logic [31:0] digest_w4;
	} dig_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] POS_LAST  = 6'd63;
	localparam logic [5:0] POS_LEN   = 6'd56;
	localparam logic [6:0] RND_LAST  = 7'd79;
	localparam logic [6:0] RND_SEC1  = 7'd20;
	localparam logic [6:0] RND_SEC2  = 7'd40;
	localparam logic [6:0] RND_SEC3  = 7'd60;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

/* rtl/sha1_hash.sv */
// Streaming SHA-1 digest engine.
// The msg channel carries one item per message byte (op absorb) or one item that
// ends the message (op finish). The dig channel carries one item per finished
// message: the five chaining words, digest bytes 0 to 19 in big-endian order.
// An absorb item is taken while msg_stall is low. The 64th byte of a block also
// starts the compression, which runs one round per cycle through a single round
// unit and then adds into the chaining words, so msg_stall stays high until
// that addition is done. A finish item feeds padding and length bytes through
// the same byte path at one byte per cycle (9 to 72 bytes) with one or two
// compressions in between, then loads the output register.
// The digest waits in the output register while dig_stall is high, and absorb
// items of the next message are still taken meanwhile; a later finish waits
// for the register to empty before its digest is loaded.
// Reset clears the bit count, loads the initial chaining words and empties the
// output register.
module sha1_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  sha1_pkg::msg_t      msg,
	output logic                dig_valid,
	input  logic                dig_stall,
	output sha1_pkg::dig_t      dig
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_ADD,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [6:0]       rnd_q;
	logic [511:0]     blk_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [4:0][31:0] h_q;
	logic [63:0]      cnt_q;
	logic [63:0]      len_q;
	logic             pad_q;
	logic             mark_q;
	logic             lenph_q;
	logic             last_q;
	sha1_pkg::dig_t   dig_q;
	logic             dig_valid_q;

	logic [5:0]  pos;
	logic        put_en;
	logic [7:0]  put_byte;
	logic [31:0] w0, w_new, f, k, t;

	assign pos = cnt_q[8:3];
	assign msg_stall = (state_q != S_IDLE);
	assign dig_valid = dig_valid_q;
	assign dig = dig_q;

	always_comb begin
		put_en = 1'b0;
		put_byte = msg.data_byte;
		if (state_q == S_IDLE) begin
			put_en = msg_valid && (msg.op == sha1_pkg::OP_ABSORB);
		end else if (state_q == S_PAD) begin
			put_en = 1'b1;
			if (mark_q) begin
				put_byte = sha1_pkg::PAD_MARK;
			end else if (lenph_q) begin
				put_byte = len_q[63:56];
			end else begin
				put_byte = 8'h00;
			end
		end
	end

	assign w0 = blk_q[511:480];
	assign w_new = sha1_pkg::rotl1(blk_q[511-13*32 -: 32] ^ blk_q[511-8*32 -: 32]
		^ blk_q[511-2*32 -: 32] ^ w0);

	always_comb begin
		if (rnd_q < sha1_pkg::RND_SEC1) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K_0;
		end else if (rnd_q < sha1_pkg::RND_SEC2) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K_1;
		end else if (rnd_q < sha1_pkg::RND_SEC3) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K_3;
		end
	end

	assign t = sha1_pkg::rotl5(a_q) + f + e_q + k + w0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q <= '0;
			blk_q <= '0;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
			h_q <= sha1_pkg::H_INIT;
			cnt_q <= '0;
			len_q <= '0;
			pad_q <= 1'b0;
			mark_q <= 1'b0;
			lenph_q <= 1'b0;
			last_q <= 1'b0;
			dig_q <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			if (dig_valid_q && !dig_stall && state_q != S_OUT) begin
				dig_valid_q <= 1'b0;
			end
			if (put_en) begin
				blk_q <= {blk_q[503:0], put_byte};
				cnt_q <= cnt_q + 64'd8;
				if (pos == sha1_pkg::POS_LAST) begin
					a_q <= h_q[0];
					b_q <= h_q[1];
					c_q <= h_q[2];
					d_q <= h_q[3];
					e_q <= h_q[4];
					rnd_q <= '0;
					last_q <= (state_q == S_PAD) && lenph_q;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg_valid && msg.op == sha1_pkg::OP_FINISH) begin
						len_q <= cnt_q;
						pad_q <= 1'b1;
						mark_q <= 1'b1;
						lenph_q <= 1'b0;
						state_q <= S_PAD;
					end else if (put_en && pos == sha1_pkg::POS_LAST) begin
						state_q <= S_ROUND;
					end
				end
				S_PAD: begin
					mark_q <= 1'b0;
					if (lenph_q) begin
						len_q <= {len_q[55:0], 8'h00};
					end else if (pos + 6'd1 == sha1_pkg::POS_LEN) begin
						lenph_q <= 1'b1;
					end
					if (pos == sha1_pkg::POS_LAST) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					blk_q <= {blk_q[479:0], w_new};
					a_q <= t;
					b_q <= a_q;
					c_q <= sha1_pkg::rotl30(b_q);
					d_q <= c_q;
					e_q <= d_q;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1_pkg::RND_LAST) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (last_q) begin
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!dig_valid_q || !dig_stall) begin
						dig_q.digest_w0 <= h_q[0];
						dig_q.digest_w1 <= h_q[1];
						dig_q.digest_w2 <= h_q[2];
						dig_q.digest_w3 <= h_q[3];
						dig_q.digest_w4 <= h_q[4];
						dig_valid_q <= 1'b1;
						h_q <= sha1_pkg::H_INIT;
						cnt_q <= '0;
						pad_q <= 1'b0;
						last_q <= 1'b0;
						lenph_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/sha1_chk.sv */
`include "assert_macros.svh"

module sha1_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           msg_valid,
	input logic           msg_stall,
	input sha1_pkg::msg_t msg,
	input logic           dig_valid,
	input logic           dig_stall,
	input sha1_pkg::dig_t dig
);

	logic fin_acc;

	assign fin_acc = msg_valid && !msg_stall && (msg.op == sha1_pkg::OP_FINISH);

	`ASSERT_CLK(a_dig_hold, dig_valid && dig_stall |=> dig_valid && $stable(dig), "digest item changed while stalled")
	`ASSERT_NEXT(a_fin_busy, fin_acc, msg_stall ##1 msg_stall, "finish item did not occupy the block")
	`ASSERT_CLK(a_dig_source, $rose(dig_valid) |-> $past(msg_stall), "digest item appeared while the block was idle")

endmodule

bind sha1_hash sha1_chk u_chk (.*);
